@@ hdl/gtm_pkg.sv @@
// Shared types and constants for the grid transform metrics pipeline.
package gtm_pkg;

	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int JAC_W   = PROD_W + 1;
	localparam int TAG_W   = 10;
	localparam int OUT_W   = 32;
	localparam int DVS_W   = JAC_W + 1;
	localparam int DVD_W   = DIFF_W + OUT_W + 2;
	localparam int LANES   = 4;
	localparam int IN_W    = 168;
	localparam int OUT_TD_W = 184;

	localparam logic signed [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// One lane of the long division: remainder, remaining dividend bits,
	// divisor, partial quotient, result sign and overflow.
	typedef struct packed {
		logic [DVS_W-1:0] rem;
		logic [OUT_W-1:0] a_lo;
		logic [DVS_W-1:0] dvs;
		logic [OUT_W-1:0] quo;
		logic             neg;
		logic             ovf;
	} div_lane_t;

	typedef struct packed {
		logic [TAG_W-1:0] col;
		logic [TAG_W-1:0] row;
		logic [OUT_W-1:0] jac;
		logic             degen;
	} side_t;

endpackage

@@ hdl/gtm_front.sv @@
// Differences, Jacobian and dividend set-up stages of the metrics pipeline.
module gtm_front
	import gtm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [COORD_W-1:0]  cx,
	input  logic signed [COORD_W-1:0]  cy,
	input  logic signed [COORD_W-1:0]  wx,
	input  logic signed [COORD_W-1:0]  wy,
	input  logic signed [COORD_W-1:0]  sx,
	input  logic signed [COORD_W-1:0]  sy,
	input  logic [TAG_W-1:0]           col,
	input  logic [TAG_W-1:0]           row,
	output logic                       out_valid,
	output div_lane_t                  lanes [LANES],
	output side_t                      side
);

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0]  xxi_s1, yxi_s1, xeta_s1, yeta_s1;
	logic signed [DIFF_W-1:0]  xxi_s2, yxi_s2, xeta_s2, yeta_s2;
	logic signed [DIFF_W-1:0]  xxi_s3, yxi_s3, xeta_s3, yeta_s3;
	logic signed [PROD_W-1:0]  p1_s2, p2_s2;
	logic [JAC_W-1:0]          jmag_s3;
	logic                      jneg_s3, degen_s3;
	logic [TAG_W-1:0]          col_s1, col_s2, col_s3, row_s1, row_s2, row_s3;
	div_lane_t                 lane_s4 [LANES];
	side_t                     side_s4;

	logic signed [JAC_W-1:0]   jac_d;
	logic signed [DIFF_W-1:0]  num_d [LANES];
	logic                      num_pos [LANES];
	logic [DVD_W-1:0]          dvd [LANES];
	logic [DVS_W-1:0]          hi_ext [LANES];
	logic [DVS_W-1:0]          dvs;
	logic [DVS_W-1:0]          jr;
	logic [OUT_W-1:0]          jac_sat;
	div_lane_t                 lane_d [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xxi_s1  <= DIFF_W'(cx) - DIFF_W'(wx);
			yxi_s1  <= DIFF_W'(cy) - DIFF_W'(wy);
			xeta_s1 <= DIFF_W'(cx) - DIFF_W'(sx);
			yeta_s1 <= DIFF_W'(cy) - DIFF_W'(sy);
			col_s1  <= col;
			row_s1  <= row;

			p1_s2   <= xxi_s1 * yeta_s1;
			p2_s2   <= xeta_s1 * yxi_s1;
			xxi_s2  <= xxi_s1;
			yxi_s2  <= yxi_s1;
			xeta_s2 <= xeta_s1;
			yeta_s2 <= yeta_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;

			jneg_s3  <= jac_d[JAC_W-1];
			jmag_s3  <= jac_d[JAC_W-1] ? JAC_W'(-jac_d) : JAC_W'(jac_d);
			degen_s3 <= (jac_d == '0);
			xxi_s3   <= xxi_s2;
			yxi_s3   <= yxi_s2;
			xeta_s3  <= xeta_s2;
			yeta_s3  <= yeta_s2;
			col_s3   <= col_s2;
			row_s3   <= row_s2;

			lane_s4 <= lane_d;
			side_s4 <= '{col: col_s3, row: row_s3, jac: jac_sat, degen: degen_s3};
		end
	end

	assign jac_d = JAC_W'(p1_s2) - JAC_W'(p2_s2);

	// Lanes: y_eta, -x_eta, -y_xi, x_xi; positive flag is the numerator sign.
	assign num_d[0] = yeta_s3;
	assign num_d[1] = xeta_s3;
	assign num_d[2] = yxi_s3;
	assign num_d[3] = xxi_s3;
	assign num_pos[0] = !yeta_s3[DIFF_W-1];
	assign num_pos[1] = xeta_s3[DIFF_W-1] || (xeta_s3 == '0);
	assign num_pos[2] = yxi_s3[DIFF_W-1] || (yxi_s3 == '0);
	assign num_pos[3] = !xxi_s3[DIFF_W-1];

	assign dvs = {jmag_s3, 1'b0};

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			logic [DIFF_W-1:0] nmag;
			nmag = num_d[k][DIFF_W-1] ? DIFF_W'(-num_d[k]) : DIFF_W'(num_d[k]);
			dvd[k] = {1'b0, nmag, {(OUT_W+1){1'b0}}} + DVD_W'(jmag_s3);
			hi_ext[k] = DVS_W'(dvd[k][DVD_W-1:OUT_W]);
			lane_d[k].ovf  = (hi_ext[k] >= dvs);
			lane_d[k].rem  = lane_d[k].ovf ? '0 : hi_ext[k];
			lane_d[k].a_lo = dvd[k][OUT_W-1:0];
			lane_d[k].dvs  = dvs;
			lane_d[k].quo  = '0;
			lane_d[k].neg  = num_pos[k] == jneg_s3;
		end
	end

	// Round half away from zero, then clamp.
	assign jr = (DVS_W'(jmag_s3) + DVS_W'(17'h08000)) >> 16;

	always_comb begin
		if (jneg_s3) begin
			jac_sat = (jr >= DVS_W'(33'h080000000)) ? Q_MIN : OUT_W'(-jr);
		end else begin
			jac_sat = (jr > DVS_W'(Q_MAX)) ? Q_MAX : jr[OUT_W-1:0];
		end
	end

	assign out_valid = v_s4;
	assign lanes     = lane_s4;
	assign side      = side_s4;

endmodule

@@ hdl/gtm_divider.sv @@
// Restoring divider, one quotient bit per pipeline stage.
module gtm_divider
	import gtm_pkg::*;
(
	input  logic      clk,
	input  logic      en,
	input  div_lane_t lane_in,
	output div_lane_t lane_out
);

	div_lane_t st [OUT_W+1];

	assign st[0] = lane_in;

	for (genvar k = 0; k < OUT_W; k++) begin : g_step
		logic [DVS_W:0] trial;
		logic           ge;

		assign trial = {st[k].rem, st[k].a_lo[OUT_W-1-k]};
		assign ge    = trial >= {1'b0, st[k].dvs};

		always_ff @(posedge clk) begin
			if (en) begin
				st[k+1].rem  <= ge ? DVS_W'(trial - {1'b0, st[k].dvs}) : DVS_W'(trial);
				st[k+1].a_lo <= st[k].a_lo;
				st[k+1].dvs  <= st[k].dvs;
				st[k+1].quo  <= {st[k].quo[OUT_W-2:0], ge};
				st[k+1].neg  <= st[k].neg;
				st[k+1].ovf  <= st[k].ovf;
			end
		end
	end

	assign lane_out = st[OUT_W];

endmodule

@@ hdl/grid_transform_metrics_2d_top.sv @@
// Top level of the 2D curvilinear grid metrics pipeline.
//
// Takes one cell per clock unless the output stalls, and returns its Jacobian
// and the four inverse metrics: front stages form differences, products, J
// and the dividends, then each metric runs through a 32-stage restoring
// divider (one quotient bit per stage), and a last stage applies the sign,
// clamps and registers the result. The whole pipe holds together when the
// output is stalled, so back-pressure reaches the input in the same cycle.
module grid_transform_metrics_2d_top
	import gtm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// center_x, center_y, west_x, west_y, south_x, south_y, cell_col, cell_row
	input  logic [IN_W-1:0]     s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// col_tag, row_tag, xi_dx, xi_dy, eta_dx, eta_dy, jacobian
	output logic [OUT_TD_W-1:0] m_tdata,
	// degenerate
	output logic                m_tuser
);

	logic       en;
	logic       fr_valid;
	div_lane_t  fr_lanes [LANES];
	div_lane_t  dv_lanes [LANES];
	side_t      fr_side;
	side_t      side_q [OUT_W];
	logic       v_q    [OUT_W];
	logic [OUT_W-1:0] metric [LANES];
	logic       out_v_q;
	logic [OUT_TD_W-1:0] out_data_q;
	logic       out_degen_q;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	gtm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.cx        (s_tdata[23:0]),
		.cy        (s_tdata[47:24]),
		.wx        (s_tdata[71:48]),
		.wy        (s_tdata[95:72]),
		.sx        (s_tdata[119:96]),
		.sy        (s_tdata[143:120]),
		.col       (s_tdata[153:144]),
		.row       (s_tdata[163:154]),
		.out_valid (fr_valid),
		.lanes     (fr_lanes),
		.side      (fr_side)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		gtm_divider u_div (
			.clk      (clk),
			.en       (en),
			.lane_in  (fr_lanes[l]),
			.lane_out (dv_lanes[l])
		);

		always_comb begin
			logic big;
			big = dv_lanes[l].ovf || dv_lanes[l].quo[OUT_W-1];
			if (side_q[OUT_W-1].degen) begin
				metric[l] = '0;
			end else if (dv_lanes[l].neg) begin
				metric[l] = big ? Q_MIN : OUT_W'(-dv_lanes[l].quo);
			end else begin
				metric[l] = big ? Q_MAX : dv_lanes[l].quo;
			end
		end
	end

	// Tags, J and flag ride alongside the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < OUT_W; k++) v_q[k] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_q[0] <= fr_valid;
			for (int k = 1; k < OUT_W; k++) v_q[k] <= v_q[k-1];
			out_v_q <= v_q[OUT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= fr_side;
			for (int k = 1; k < OUT_W; k++) side_q[k] <= side_q[k-1];
			out_data_q <= {4'b0, side_q[OUT_W-1].jac, metric[3], metric[2], metric[1],
				metric[0], side_q[OUT_W-1].row, side_q[OUT_W-1].col};
			out_degen_q <= side_q[OUT_W-1].degen;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_degen_q;

endmodule

@@ hdl/gtm_checker.sv @@
// Port-level checks for the grid metrics pipeline, bound to the top level.
module gtm_checker
	import gtm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OUT_TD_W-1:0] m_tdata,
	input logic                m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[179:20] == '0)
		else $error("degenerate cell with non-zero metrics");

endmodule

bind grid_transform_metrics_2d_top gtm_checker u_gtm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ sim/grid_transform_metrics_2d_checker.sv @@
// Output checker for the grid transform metrics pipeline: predicts each cell and compares.
module grid_transform_metrics_2d_checker
	import gtm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [IN_W-1:0]     s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OUT_TD_W-1:0] m_tdata,
	input  logic                m_tuser,
	output int                  errors,
	output int                  pending
);

	typedef struct {
		logic [OUT_TD_W-1:0] data;
		logic                degen;
	} cell_result_t;

	cell_result_t metrics_q[$];

	function automatic logic [31:0] clamp_q16(input logic [63:0] m, input logic neg);
		if (neg) begin
			if (m >= 64'h8000_0000)
				return Q_MIN;
			return -m[31:0];
		end
		if (m > 64'h7FFF_FFFF)
			return Q_MAX;
		return m[31:0];
	endfunction

	function automatic logic [63:0] magnitude(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// Quotient of a Q9.16 difference over the exact Q18.32 J, rounded half away.
	function automatic logic [31:0] inverse_metric(input logic signed [63:0] d,
			input logic signed [63:0] jx);
		logic [63:0] num, den, q;
		num = magnitude(d) << 32;
		den = magnitude(jx);
		q = (2 * num + den) / (2 * den);
		return clamp_q16(q, (d < 0) != (jx < 0));
	endfunction

	function automatic cell_result_t predict_cell(input logic [IN_W-1:0] td);
		logic signed [63:0] c[6];
		logic signed [63:0] x_xi, y_xi, x_eta, y_eta, jx;
		logic [31:0] xdx, xdy, edx, edy, jac;
		cell_result_t r;
		for (int k = 0; k < 6; k++)
			c[k] = 64'(signed'(td[k*COORD_W +: COORD_W]));
		x_xi = c[0] - c[2];
		y_xi = c[1] - c[3];
		x_eta = c[0] - c[4];
		y_eta = c[1] - c[5];
		jx = x_xi * y_eta - x_eta * y_xi;
		{xdx, xdy, edx, edy, jac} = '0;
		r.degen = (jx == 0);
		if (!r.degen) begin
			jac = clamp_q16((magnitude(jx) + 64'h8000) >> 16, jx < 0);
			xdx = inverse_metric(y_eta, jx);
			xdy = inverse_metric(-x_eta, jx);
			edx = inverse_metric(-y_xi, jx);
			edy = inverse_metric(x_xi, jx);
		end
		r.data = {jac, edy, edx, xdy, xdx, td[6*COORD_W+TAG_W +: TAG_W],
			td[6*COORD_W +: TAG_W]};
		return r;
	endfunction

	assign pending = metrics_q.size();

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (s_tvalid && s_tready)
				metrics_q.push_back(predict_cell(s_tdata));
			if (m_tvalid && m_tready) begin
				if (metrics_q.size() == 0) begin
					$display("%0t: unexpected transfer, actual %h/%b", $time, m_tdata, m_tuser);
					errors <= errors + 1;
				end else begin
					want = metrics_q.pop_front();
					if (want.data !== m_tdata || want.degen !== m_tuser) begin
						$display("%0t: mismatch, expected %h/%b actual %h/%b", $time,
							want.data, want.degen, m_tdata, m_tuser);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

@@ sim/grid_transform_metrics_2d_top_test.sv @@
// Stimulus and verdict for the grid transform metrics pipeline.
module grid_transform_metrics_2d_top_test;
	import gtm_pkg::*;

	localparam int LATENCY = 37;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_TD_W-1:0] m_tdata;
	logic                m_tuser;
	int                  errors, pending;
	bit                  no_idle = 1'b0;
	bit                  hold_off = 1'b0;

	always #6 clk = ~clk;

	grid_transform_metrics_2d_top uut (.*);
	grid_transform_metrics_2d_checker chk (.*);

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	// Centre plus small or large offsets; sometimes collinear or coincident.
	function automatic logic [IN_W-1:0] random_cell();
		logic [23:0] p[6];
		logic signed [23:0] dx, dy;
		p[0] = rand_coord();
		p[1] = rand_coord();
		for (int k = 2; k < 6; k++)
			p[k] = ($urandom_range(0, 2) == 0) ? rand_coord()
				: p[k & 1] - 24'($urandom_range(0, 1 << $urandom_range(1, 20)));
		if ($urandom_range(0, 15) == 0) begin
			dx = p[0] - p[2];
			dy = p[1] - p[3];
			p[4] = p[0] - 24'(2 * dx);
			p[5] = p[1] - 24'(2 * dy);
		end
		return {4'b0, 10'($urandom), 10'($urandom), p[5], p[4], p[3], p[2], p[1], p[0]};
	endfunction

	task automatic send_cell(input logic [IN_W-1:0] item_td);
		while (!no_idle && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= item_td;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic logic [IN_W-1:0] pack_cell(input logic [23:0] cx, cy, wx, wy,
			sx, sy, input logic [9:0] col, row);
		return {4'b0, row, col, sy, sx, wy, wx, cy, cx};
	endfunction

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= !hold_off && (no_idle || $urandom_range(0, 99) >= 19);
	end

	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int waited;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// unit square, degenerate, extremes, tiny J, tag extremes
		send_cell(pack_cell(24'h010000, 24'h010000, 0, 24'h010000, 24'h010000, 0, 0, 0));
		send_cell(pack_cell(5, 7, 5, 7, 5, 7, 10'h3FF, 10'h3FF));
		send_cell(pack_cell(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
			24'h7FFFFF, 24'h800000, 10'h3FF, 0));
		send_cell(pack_cell(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
			24'h800000, 24'h7FFFFF, 0, 10'h3FF));
		send_cell(pack_cell(24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
			24'h7FFFFF, 24'h7FFFFF, 1, 2));
		send_cell(pack_cell(1, 1, 0, 1, 1, 0, 3, 4));
		send_cell(pack_cell(1, 0, 0, 0, 0, 1, 5, 6));
		send_cell(pack_cell(24'h000100, 0, 0, 0, 0, 24'h000080, 7, 8));
		send_cell(pack_cell(24'h7FFFFF, 0, 0, 0, 0, 1, 9, 10));
		send_cell(pack_cell(0, 0, 24'h010000, 24'h010000, 24'h020000, 24'h020000, 11, 12));
		send_cell(pack_cell(24'hFFFFFF, 24'hFFFFFF, 24'h555555, 24'hAAAAAA,
			24'hAAAAAA, 24'h555555, 10'h2AA, 10'h155));
		// hold the receiver off while cells keep coming
		hold_off = 1'b1;
		fork
			begin
				repeat (120) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int n = 0; n < 80; n++)
				send_cell(random_cell());
		join
		for (int n = 0; n < 960; n++) begin
			no_idle = (n >= 400 && n < 550);
			send_cell(random_cell());
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;
		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
